// ===== hdl/pixel_point_operation_unit_macros.svh =====
// assertion macros for the pixel point operation unit
`ifndef PIXEL_POINT_OPERATION_UNIT_MACROS_SVH
`define PIXEL_POINT_OPERATION_UNIT_MACROS_SVH

// same-cycle implication
`define PPOU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppou assertion failed");

// next-cycle implication
`define PPOU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppou assertion failed");

`endif

// ===== hdl/ppou_pkg.sv =====
package ppou_pkg;

    typedef enum logic [2:0] {
        MODE_NEGATIVE   = 3'd0,
        MODE_BRIGHTNESS = 3'd1,
        MODE_CONTRAST   = 3'd2,
        MODE_GAIN_RED   = 3'd3,
        MODE_GAIN_GREEN = 3'd4,
        MODE_GAIN_BLUE  = 3'd5,
        MODE_GRAY       = 3'd6,
        MODE_THRESHOLD  = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_MAX_COLOR = 3'd1,
        REG_LEVEL     = 3'd2,
        REG_GAIN      = 3'd3,
        REG_COL_FIRST = 3'd4,
        REG_COL_LAST  = 3'd5,
        REG_ROW_FIRST = 3'd6,
        REG_ROW_LAST  = 3'd7
    } reg_index_t;

    localparam int CfgDataWidth = 16;
    localparam int MaxDim       = 4096;

    localparam logic [15:0] GrayWeightRed   = 16'd19595;
    localparam logic [15:0] GrayWeightGreen = 16'd38470;
    localparam logic [15:0] GrayWeightBlue  = 16'd7471;

    // floor(sum / 3) == (sum * 683) >> 11 for sum up to 765
    localparam logic [9:0] ThirdRecip = 10'd683;
    localparam int         ThirdShift = 11;

    typedef struct packed {
        mode_t              mode;
        logic [7:0]         max_color;
        logic signed [8:0]  level;
        logic signed [15:0] gain;
        logic [11:0]        col_first;
        logic [11:0]        col_last;
        logic [11:0]        row_first;
        logic [11:0]        row_last;
    } cfg_t;

    localparam cfg_t CfgReset = '{
        mode:      MODE_NEGATIVE,
        max_color: 8'd255,
        level:     9'sd0,
        gain:      16'sd256,
        col_first: 12'd0,
        col_last:  12'd4095,
        row_first: 12'd0,
        row_last:  12'd4095
    };

    typedef struct packed {
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [11:0] column;
        logic [11:0] row;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pixel_out_t;

    function automatic logic [7:0] sat_color(input logic signed [17:0] v,
                                             input logic [7:0] top);
        logic [7:0] r;
        if (v < 18'sd0)
        begin
            r = 8'd0;
        end
        else if (v > signed'({10'd0, top}))
        begin
            r = top;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/ppou_lane.sv =====
module ppou_lane
    import ppou_pkg::*;
(
    input  logic [7:0] color,
    input  cfg_t       cfg,
    input  logic       gain_sel,
    output logic [7:0] result
);

    logic signed [9:0]  c_s;
    logic signed [9:0]  m_s;
    logic signed [9:0]  diff;
    logic signed [9:0]  bright;
    logic signed [9:0]  operand;
    logic signed [25:0] prod;
    logic signed [26:0] contrast_sum;
    logic signed [17:0] contrast_q;
    logic signed [17:0] gain_q;

    always_comb
    begin
        c_s     = signed'({2'b00, color});
        m_s     = signed'({2'b00, cfg.max_color});
        diff    = m_s - c_s;
        bright  = c_s + 10'(cfg.level);
        operand = (cfg.mode == MODE_CONTRAST) ? ((c_s <<< 1) - m_s) : c_s;
        prod    = 26'(operand) * 26'(cfg.gain);
        // floor shifts on signed values
        contrast_sum = (27'(m_s) <<< 8) + 27'(prod);
        contrast_q   = 18'(contrast_sum >>> 9);
        gain_q       = 18'(prod >>> 8);
    end

    always_comb
    begin
        unique case (cfg.mode)
            MODE_NEGATIVE:   result = sat_color(18'(diff), cfg.max_color);
            MODE_BRIGHTNESS: result = sat_color(18'(bright), cfg.max_color);
            MODE_CONTRAST:   result = sat_color(contrast_q, cfg.max_color);
            MODE_GAIN_RED,
            MODE_GAIN_GREEN,
            MODE_GAIN_BLUE:  result = gain_sel ? sat_color(gain_q, cfg.max_color) : color;
            MODE_GRAY,
            MODE_THRESHOLD:  result = color;
        endcase
    end

endmodule

// ===== hdl/pixel_point_operation_unit.sv =====
// an accepted input beat passes the input register, then single-pass logic, then the output register
// throughput: one pixel per clock while out_stall does not hold back a full output register
// in_stall rises only when both the input and output registers hold unaccepted beats
// reset (rst_n low, asynchronous) empties both registers and loads register reset values
// cfg_ready is always high
`include "pixel_point_operation_unit_macros.svh"

module pixel_point_operation_unit
    import ppou_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  pixel_in_t               in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output pixel_out_t              out_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    pixel_in_t  s1_data_reg;
    pixel_in_t  s1_data_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    pixel_out_t out_data_reg;
    pixel_out_t out_data_next;

    logic       s1_en;
    logic       s2_en;
    logic       in_region;
    logic [7:0] lane_red;
    logic [7:0] lane_green;
    logic [7:0] lane_blue;
    logic [23:0] gray_sum;
    logic [7:0] gray_val;
    logic [9:0] chan_sum;
    logic [19:0] third_prod;
    logic [7:0] mean;
    logic [7:0] thr_val;
    pixel_out_t result;

    assign cfg_ready = 1'b1;

    // config registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MODE:      cfg_next.mode      = mode_t'(cfg_data[2:0]);
                REG_MAX_COLOR: cfg_next.max_color = cfg_data[7:0];
                REG_LEVEL:     cfg_next.level     = signed'(cfg_data[8:0]);
                REG_GAIN:      cfg_next.gain      = signed'(cfg_data[15:0]);
                REG_COL_FIRST: cfg_next.col_first = cfg_data[11:0];
                REG_COL_LAST:  cfg_next.col_last  = cfg_data[11:0];
                REG_ROW_FIRST: cfg_next.row_first = cfg_data[11:0];
                REG_ROW_LAST:  cfg_next.row_last  = cfg_data[11:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CfgReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // pipeline control
    assign s2_en    = !out_valid_reg || !out_stall;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_stall = !s1_en;

    always_comb
    begin
        s1_valid_next  = s1_en ? in_valid : s1_valid_reg;
        s1_data_next   = (s1_en && in_valid) ? in_data : s1_data_reg;
        out_valid_next = s2_en ? s1_valid_reg : out_valid_reg;
        out_data_next  = (s2_en && s1_valid_reg) ? result : out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_data_reg  <= s1_data_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // region test
    always_comb
    begin
        in_region = (32'(s1_data_reg.column) < MaxDim) && (32'(s1_data_reg.row) < MaxDim) &&
                    (s1_data_reg.column >= cfg_reg.col_first) &&
                    (s1_data_reg.column <= cfg_reg.col_last) &&
                    (s1_data_reg.row >= cfg_reg.row_first) &&
                    (s1_data_reg.row <= cfg_reg.row_last);
    end

    ppou_lane u_lane_red
    (
        .color    (s1_data_reg.red_in),
        .cfg      (cfg_reg),
        .gain_sel (cfg_reg.mode == MODE_GAIN_RED),
        .result   (lane_red)
    );

    ppou_lane u_lane_green
    (
        .color    (s1_data_reg.green_in),
        .cfg      (cfg_reg),
        .gain_sel (cfg_reg.mode == MODE_GAIN_GREEN),
        .result   (lane_green)
    );

    ppou_lane u_lane_blue
    (
        .color    (s1_data_reg.blue_in),
        .cfg      (cfg_reg),
        .gain_sel (cfg_reg.mode == MODE_GAIN_BLUE),
        .result   (lane_blue)
    );

    // grayscale and threshold
    always_comb
    begin
        gray_sum = 24'(s1_data_reg.red_in) * 24'(GrayWeightRed) +
                   24'(s1_data_reg.green_in) * 24'(GrayWeightGreen) +
                   24'(s1_data_reg.blue_in) * 24'(GrayWeightBlue);
        gray_val = (gray_sum[23:16] > cfg_reg.max_color) ? cfg_reg.max_color : gray_sum[23:16];

        chan_sum   = 10'(s1_data_reg.red_in) + 10'(s1_data_reg.green_in) +
                     10'(s1_data_reg.blue_in);
        third_prod = 20'(chan_sum) * 20'(ThirdRecip);
        mean       = 8'(third_prod >> ThirdShift);
        thr_val    = (signed'({2'b00, mean}) >= 10'(cfg_reg.level)) ? cfg_reg.max_color : 8'd0;
    end

    always_comb
    begin
        if (!in_region)
        begin
            result.red_out   = s1_data_reg.red_in;
            result.green_out = s1_data_reg.green_in;
            result.blue_out  = s1_data_reg.blue_in;
        end
        else
        begin
            unique case (cfg_reg.mode)
                MODE_GRAY:
                begin
                    result.red_out   = gray_val;
                    result.green_out = gray_val;
                    result.blue_out  = gray_val;
                end
                MODE_THRESHOLD:
                begin
                    result.red_out   = thr_val;
                    result.green_out = thr_val;
                    result.blue_out  = thr_val;
                end
                MODE_NEGATIVE,
                MODE_BRIGHTNESS,
                MODE_CONTRAST,
                MODE_GAIN_RED,
                MODE_GAIN_GREEN,
                MODE_GAIN_BLUE:
                begin
                    result.red_out   = lane_red;
                    result.green_out = lane_green;
                    result.blue_out  = lane_blue;
                end
            endcase
        end
    end

    // stall only with both registers full
    `PPOU_ASSERT_IMPL(a_stall_full, in_stall, s1_valid_reg && out_valid_reg)
    // a held beat moves into an empty output register
    `PPOU_ASSERT_NEXT(a_fill, s1_valid_reg && !out_valid_reg, out_valid_reg)
    // output empties when its beat leaves and nothing is behind it
    `PPOU_ASSERT_NEXT(a_drain, out_valid_reg && !out_stall && !s1_valid_reg, !out_valid_reg)

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ppou_pkg::*;

    localparam int WatchdogLimit = 3000;
    localparam int HoldCycles    = 48;
    localparam int PhaseCount    = 24;
    localparam int PhaseItems    = 65;

    class point_op_checker;
        mode_t       mode      = MODE_NEGATIVE;
        logic [7:0]  max_color = 8'd255;
        int          level     = 0;
        int          gain      = 256;
        logic [11:0] col_first = 12'd0;
        logic [11:0] col_last  = 12'd4095;
        logic [11:0] row_first = 12'd0;
        logic [11:0] row_last  = 12'd4095;

        pixel_out_t  pending_pixels[$];
        int          checked    = 0;
        int          mismatches = 0;

        function void set_reg(reg_index_t idx, logic [15:0] data);
            case (idx)
                REG_MODE:      mode = mode_t'(data[2:0]);
                REG_MAX_COLOR: max_color = data[7:0];
                REG_LEVEL:     level = $signed(data[8:0]);
                REG_GAIN:      gain = $signed(data);
                REG_COL_FIRST: col_first = data[11:0];
                REG_COL_LAST:  col_last = data[11:0];
                REG_ROW_FIRST: row_first = data[11:0];
                REG_ROW_LAST:  row_last = data[11:0];
            endcase
        endfunction

        function logic [7:0] clamp_color(longint v);
            if (v < 0)
                return 8'd0;
            if (v > longint'(max_color))
                return max_color;
            return v[7:0];
        endfunction

        function pixel_out_t apply_point_op(pixel_in_t p);
            longint     ch[3];
            logic [7:0] res[3];
            longint     m;
            longint     acc;
            int         k;
            pixel_out_t o;
            ch[0] = p.red_in;
            ch[1] = p.green_in;
            ch[2] = p.blue_in;
            m = max_color;
            for (int i = 0; i < 3; i++)
                res[i] = ch[i][7:0];
            if (p.column >= col_first && p.column <= col_last &&
                p.row >= row_first && p.row <= row_last)
            begin
                case (mode)
                    MODE_NEGATIVE:
                        for (int i = 0; i < 3; i++)
                            res[i] = clamp_color(m - ch[i]);
                    MODE_BRIGHTNESS:
                        for (int i = 0; i < 3; i++)
                            res[i] = clamp_color(ch[i] + longint'(level));
                    MODE_CONTRAST:
                        for (int i = 0; i < 3; i++)
                        begin
                            acc = m * 256 + longint'(gain) * (2 * ch[i] - m);
                            res[i] = clamp_color(acc >>> 9);
                        end
                    MODE_GAIN_RED, MODE_GAIN_GREEN, MODE_GAIN_BLUE:
                    begin
                        k = int'(mode) - int'(MODE_GAIN_RED);
                        acc = ch[k] * longint'(gain);
                        res[k] = clamp_color(acc >>> 8);
                    end
                    MODE_GRAY:
                    begin
                        acc = (19595 * ch[0] + 38470 * ch[1] + 7471 * ch[2]) >>> 16;
                        res[0] = clamp_color(acc);
                        res[1] = res[0];
                        res[2] = res[0];
                    end
                    MODE_THRESHOLD:
                    begin
                        acc = (ch[0] + ch[1] + ch[2]) / 3;
                        res[0] = (acc >= longint'(level)) ? max_color : 8'd0;
                        res[1] = res[0];
                        res[2] = res[0];
                    end
                endcase
            end
            o.red_out   = res[0];
            o.green_out = res[1];
            o.blue_out  = res[2];
            return o;
        endfunction

        function void note_pixel(pixel_in_t p);
            pending_pixels.push_back(apply_point_op(p));
        endfunction

        function void check_pixel(pixel_out_t got);
            pixel_out_t want;
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: output beat r=%0d g=%0d b=%0d with nothing pending",
                             $time, got.red_out, got.green_out, got.blue_out);
                return;
            end
            want = pending_pixels.pop_front();
            checked++;
            if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
                got.blue_out !== want.blue_out)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                             $time, want.red_out, want.green_out, want.blue_out,
                             got.red_out, got.green_out, got.blue_out);
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    pixel_in_t               in_data;
    logic                    out_valid;
    logic                    out_stall;
    pixel_out_t              out_data;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [2:0]              cfg_index;
    logic [CfgDataWidth-1:0] cfg_data;

    point_op_checker board;
    bit              calm;
    bit              hold_req;
    int              pixels_sent;
    int              reg_writes;
    int              settings_used;

    pixel_point_operation_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic pixel_in_t mk_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic [11:0] col, logic [11:0] row);
        pixel_in_t p;
        p.red_in   = r;
        p.green_in = g;
        p.blue_in  = b;
        p.column   = col;
        p.row      = row;
        return p;
    endfunction

    function automatic logic [7:0] rand_chan();
        int r;
        r = $urandom_range(9, 0);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        return 8'($urandom());
    endfunction

    function automatic logic [11:0] pick_coord(logic [11:0] first, logic [11:0] last);
        int v;
        case ($urandom_range(3, 0))
            0: v = $urandom_range(4095, 0);
            1: v = int'(first) + $urandom_range(4, 0) - 2;
            2: v = int'(last) + $urandom_range(4, 0) - 2;
            default: v = (first <= last) ? $urandom_range(last, first) : $urandom_range(4095, 0);
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return 12'(v);
    endfunction

    function automatic void pick_span(output logic [11:0] first, output logic [11:0] last);
        int r;
        int v;
        r = $urandom_range(9, 0);
        if (r < 4)
        begin
            first = 12'd0;
            last  = 12'd4095;
        end
        else if (r < 7)
        begin
            first = 12'($urandom_range(4095, 0));
            v = int'(first) + $urandom_range(300, 0);
            last = (v > 4095) ? 12'd4095 : 12'(v);
        end
        else if (r < 9)
        begin
            first = 12'($urandom_range(4095, 0));
            last  = 12'($urandom_range(4095, 0));
        end
        else
        begin
            last  = 12'($urandom_range(4094, 0));
            first = last + 12'd1;
        end
    endfunction

    function automatic cfg_t rand_cfg();
        cfg_t c;
        int   r;
        c.mode = mode_t'($urandom_range(7, 0));
        r = $urandom_range(9, 0);
        if (r < 5)
            c.max_color = 8'd255;
        else if (r < 8)
            c.max_color = 8'($urandom_range(255, 1));
        else if (r == 8)
            c.max_color = 8'($urandom_range(3, 0));
        else
            c.max_color = 8'($urandom());
        case ($urandom_range(9, 0))
            0: c.level = 9'sd255;
            1: c.level = -9'sd255;
            2: c.level = 9'h100;
            3: c.level = 9'sd0;
            default: c.level = 9'($urandom_range(510, 0) - 255);
        endcase
        case ($urandom_range(9, 0))
            0: c.gain = 16'($urandom());
            1: c.gain = 16'sh7FFF;
            2: c.gain = 16'sh8000;
            3: c.gain = 16'sd0;
            4: c.gain = 16'sd256;
            default: c.gain = 16'($urandom_range(1280, 0) - 512);
        endcase
        pick_span(c.col_first, c.col_last);
        pick_span(c.row_first, c.row_last);
        return c;
    endfunction

    task automatic send_pixel(input pixel_in_t p);
        int idle;
        idle = calm ? 0 : pick_gap();
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_pixel(p);
        pixels_sent++;
    endtask

    task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [11:0] col, input logic [11:0] row);
        send_pixel(mk_pixel(r, g, b, col, row));
    endtask

    // bits above the register width carry junk
    task automatic write_reg(input reg_index_t idx, input logic [15:0] val, input int width);
        logic [15:0] word;
        word = 16'($urandom());
        for (int b = 0; b < width; b++)
            word[b] = val[b];
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(idx, word);
        reg_writes++;
    endtask

    task automatic reconfigure(input cfg_t c);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(REG_MODE, 16'(c.mode), 3);
        write_reg(REG_MAX_COLOR, 16'(c.max_color), 8);
        write_reg(REG_LEVEL, 16'(c.level), 9);
        write_reg(REG_GAIN, c.gain, 16);
        write_reg(REG_COL_FIRST, 16'(c.col_first), 12);
        write_reg(REG_COL_LAST, 16'(c.col_last), 12);
        write_reg(REG_ROW_FIRST, 16'(c.row_first), 12);
        write_reg(REG_ROW_LAST, 16'(c.row_last), 12);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid && !out_stall)
            board.check_pixel(out_data);
    end

    initial
    begin : receiver
        int run_left;
        bit stall_next;
        run_left = 0;
        stall_next = 1'b0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (run_left == 0)
            begin
                if (hold_req)
                begin
                    // long hold so the pipe fills and backs up the input
                    hold_req = 1'b0;
                    stall_next = 1'b1;
                    run_left = HoldCycles;
                end
                else if (calm)
                begin
                    stall_next = 1'b0;
                    run_left = 1;
                end
                else if ($urandom_range(2, 0) == 0)
                begin
                    stall_next = 1'b1;
                    run_left = pick_gap() + 1;
                end
                else
                begin
                    stall_next = 1'b0;
                    run_left = $urandom_range(12, 1);
                end
            end
            run_left--;
            out_stall <= stall_next;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WatchdogLimit)
            begin
                $display("timeout: no beat for %0d cycles, %0d pixels pending",
                         quiet, board.pending());
                $display("** pixel_point_operation_unit: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        cfg_t c;
        board = new;
        calm = 1'b0;
        hold_req = 1'b0;
        pixels_sent = 0;
        reg_writes = 0;
        settings_used = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_MODE;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: negative over the whole frame
        send_rgb(8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
        send_rgb(8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095);
        send_rgb(8'hAA, 8'h55, 8'h0F, 12'hAAA, 12'h555);

        // channel above max_color
        c = CfgReset;
        c.mode = MODE_BRIGHTNESS;
        c.max_color = 8'd200;
        c.level = 9'sd255;
        reconfigure(c);
        send_rgb(8'd250, 8'd0, 8'd100, 12'h555, 12'hAAA);
        c.level = -9'sd255;
        reconfigure(c);
        send_rgb(8'd255, 8'd254, 8'd10, 12'd0, 12'd4095);

        c.mode = MODE_CONTRAST;
        c.max_color = 8'd255;
        c.gain = 16'sh8000;
        reconfigure(c);
        send_rgb(8'd0, 8'd255, 8'd127, 12'd17, 12'd33);
        c.gain = 16'sh7FFF;
        reconfigure(c);
        send_rgb(8'd0, 8'd255, 8'd128, 12'd4095, 12'd0);

        // max_color zero
        c.max_color = 8'd0;
        c.gain = 16'sd384;
        reconfigure(c);
        send_rgb(8'd255, 8'd0, 8'd77, 12'd1, 12'd1);

        c.max_color = 8'd255;
        c.mode = MODE_GAIN_RED;
        c.gain = 16'sh7FFF;
        reconfigure(c);
        send_rgb(8'd255, 8'd1, 8'd2, 12'd5, 12'd6);
        c.mode = MODE_GAIN_GREEN;
        c.gain = -16'sd1;
        reconfigure(c);
        send_rgb(8'd3, 8'd200, 8'd4, 12'd7, 12'd8);
        c.mode = MODE_GAIN_BLUE;
        c.gain = 16'sd384;
        reconfigure(c);
        send_rgb(8'd10, 8'd20, 8'd171, 12'd9, 12'd10);

        c.mode = MODE_GRAY;
        reconfigure(c);
        send_rgb(8'd255, 8'd255, 8'd255, 12'd11, 12'd12);
        send_rgb(8'd255, 8'd0, 8'd0, 12'd13, 12'd14);

        c.mode = MODE_THRESHOLD;
        c.level = 9'sd255;
        reconfigure(c);
        send_rgb(8'd255, 8'd255, 8'd255, 12'd15, 12'd16);
        send_rgb(8'd255, 8'd255, 8'd254, 12'd17, 12'd18);
        c.level = 9'h100;
        reconfigure(c);
        send_rgb(8'd0, 8'd0, 8'd0, 12'd19, 12'd20);

        // region edges
        c = CfgReset;
        c.col_first = 12'd100;
        c.col_last  = 12'd200;
        c.row_first = 12'd50;
        c.row_last  = 12'd60;
        reconfigure(c);
        send_rgb(8'd1, 8'd2, 8'd3, 12'd99, 12'd55);
        send_rgb(8'd1, 8'd2, 8'd3, 12'd100, 12'd50);
        send_rgb(8'd1, 8'd2, 8'd3, 12'd200, 12'd60);
        send_rgb(8'd1, 8'd2, 8'd3, 12'd201, 12'd60);
        send_rgb(8'd1, 8'd2, 8'd3, 12'd150, 12'd61);
        send_rgb(8'd1, 8'd2, 8'd3, 12'd150, 12'd49);

        // inverted region
        c.col_first = 12'd300;
        c.col_last  = 12'd299;
        reconfigure(c);
        send_rgb(8'd40, 8'd50, 8'd60, 12'd300, 12'd55);
        send_rgb(8'd40, 8'd50, 8'd60, 12'd299, 12'd55);

        for (int ph = 0; ph < PhaseCount; ph++)
        begin
            c = rand_cfg();
            reconfigure(c);
            calm = (ph % 6 == 3) || (ph == 5);
            if (ph == 5)
                hold_req = 1'b1;
            for (int n = 0; n < PhaseItems; n++)
                send_pixel(mk_pixel(rand_chan(), rand_chan(), rand_chan(),
                                    pick_coord(c.col_first, c.col_last),
                                    pick_coord(c.row_first, c.row_last)));
            calm = 1'b0;
        end

        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("run covered %0d pixels under %0d register settings (%0d register writes)",
                 pixels_sent, settings_used, reg_writes);
        $display("%0d output beats checked, %0d mismatches", board.checked, board.mismatches);
        if (board.mismatches == 0)
            $display("** pixel_point_operation_unit: PASSED **");
        else
            $display("** pixel_point_operation_unit: FAILED **");
        $finish;
    end

endmodule
